@@ hdl/cfe_pkg.sv @@
// Shared types, constants and frame helpers for the sensor frame engine.
`default_nettype none

package cfe_pkg;

  // Input beat opcodes.
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // Frame layout and command codes.
  localparam logic [7:0] FRAME_START   = 8'hFF;
  localparam logic [7:0] FRAME_ADDR    = 8'h01;
  localparam logic [7:0] CMD_AUTO_MODE = 8'h79;
  localparam logic [7:0] CMD_READ      = 8'h86;
  localparam logic [7:0] CMD_CALIBRATE = 8'h87;
  localparam logic [3:0] FRAME_LAST    = 4'd8;

  // Frame byte positions that carry something other than zero.
  localparam logic [3:0] POS_START  = 4'd0;
  localparam logic [3:0] POS_ADDR   = 4'd1;
  localparam logic [3:0] POS_CODE   = 4'd2;
  localparam logic [3:0] POS_AUTO   = 4'd3;
  localparam logic [3:0] POS_CAL    = 4'd6;
  localparam logic [3:0] POS_CHKSUM = 4'd8;

  // Alarm levels.
  localparam logic [1:0] LEVEL_GREEN  = 2'd0;
  localparam logic [1:0] LEVEL_YELLOW = 2'd1;
  localparam logic [1:0] LEVEL_RED    = 2'd2;
  localparam logic [1:0] LEVEL_ALL    = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_WARN     = 2'd0;
  localparam logic [1:0] REG_CRITICAL = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;
  localparam logic [15:0] WARN_RESET     = 16'd1000;
  localparam logic [15:0] CRITICAL_RESET = 16'd2000;
  localparam logic [7:0]  OFFSET_RESET   = 8'd20;

  // Configuration register values.
  typedef struct packed {
    logic [15:0] warn;
    logic [15:0] critical;
    logic [7:0]  offset;
  } cfg_t;

  // Outcome of a receive beat, valid in the cycle the beat is accepted.
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [15:0] ppm;
    logic [1:0]  level;
  } rx_status_t;

  // Frame byte waiting in the transmit serializer.
  typedef struct packed {
    logic        valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] ppm;
    logic [1:0]  level;
  } ser_beat_t;

  // Byte idx of the command frame for a given command code and argument.
  function automatic logic [7:0] frame_byte(input logic [7:0] code,
                                            input logic [15:0] value,
                                            input logic [3:0] idx);
    logic [7:0] b3;
    logic [7:0] b6;
    logic [7:0] sum;
    logic [7:0] res;
    b3  = (code == CMD_AUTO_MODE) ? value[7:0] : 8'h00;
    b6  = (code == CMD_CALIBRATE) ? value[15:8] : 8'h00;
    sum = FRAME_ADDR + code + b3 + b6;
    unique case (idx)
      POS_START:  res = FRAME_START;
      POS_ADDR:   res = FRAME_ADDR;
      POS_CODE:   res = code;
      POS_AUTO:   res = b3;
      POS_CAL:    res = b6;
      POS_CHKSUM: res = ~sum + 8'd1;
      default:    res = 8'h00;
    endcase
    return res;
  endfunction

  // Alarm level for a concentration; red wins over yellow.
  function automatic logic [1:0] pick_level(input logic [15:0] ppm,
                                            input logic [15:0] warn,
                                            input logic [15:0] critical);
    logic [1:0] lvl;
    priority if (ppm > critical) begin
      lvl = LEVEL_RED;
    end else if (ppm > warn) begin
      lvl = LEVEL_YELLOW;
    end else begin
      lvl = LEVEL_GREEN;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cfe_rx.sv @@
// Response frame collector: checksum check, reading update and alarm level.
`default_nettype none

module cfe_rx (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_accept,
  input  wire logic              restart,
  input  wire logic [7:0]        rx_byte,
  input  wire cfe_pkg::cfg_t     cfg,
  output cfe_pkg::rx_status_t    status,
  output logic [15:0]            ppm_cur,
  output logic [1:0]             level_cur
);
  import cfe_pkg::*;

  logic [3:0]  rx_count;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_type_byte;
  logic [15:0] rx_raw_reading;
  logic [15:0] current_ppm;
  logic [1:0]  level_reg;

  logic        frame_end;
  logic        chk_ok;
  logic        take_reading;
  logic [15:0] ppm_new;

  // Ninth byte closes the frame; check it against the negated running sum.
  always_comb begin
    frame_end    = rx_accept && (rx_count == FRAME_LAST);
    chk_ok       = (rx_byte == (~rx_sum + 8'd1));
    take_reading = chk_ok && (rx_type_byte == CMD_READ);
    ppm_new      = rx_raw_reading + {8'h00, cfg.offset};
    status.done  = frame_end;
    status.ok    = chk_ok;
    status.ppm   = take_reading ? ppm_new : current_ppm;
    status.level = take_reading ? pick_level(ppm_new, cfg.warn, cfg.critical) : level_reg;
  end

  assign ppm_cur   = current_ppm;
  assign level_cur = level_reg;

  // Frame position, running sum and the held reading.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count       <= '0;
      rx_sum         <= '0;
      rx_type_byte   <= '0;
      rx_raw_reading <= '0;
      current_ppm    <= '0;
      level_reg      <= LEVEL_ALL;
    end else if (restart) begin
      rx_count <= '0;
      rx_sum   <= '0;
    end else if (frame_end) begin
      rx_count    <= '0;
      rx_sum      <= '0;
      current_ppm <= status.ppm;
      level_reg   <= status.level;
    end else if (rx_accept) begin
      if (rx_count == POS_ADDR) begin
        rx_type_byte <= rx_byte;
      end
      if (rx_count == POS_CODE) begin
        rx_raw_reading[15:8] <= rx_byte;
      end
      if (rx_count == POS_AUTO) begin
        rx_raw_reading[7:0] <= rx_byte;
      end
      if (rx_count != POS_START) begin
        rx_sum <= rx_sum + rx_byte;
      end
      rx_count <= rx_count + 4'd1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cfe_tx.sv @@
// Command frame serializer: hands out frame bytes one to eight after a send.
`default_nettype none

module cfe_tx (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire logic         advance,
  input  wire logic [7:0]   command_code,
  input  wire logic [15:0]  command_value,
  input  wire logic [15:0]  ppm_in,
  input  wire logic [1:0]   level_in,
  output cfe_pkg::ser_beat_t beat
);
  import cfe_pkg::*;

  logic        active;
  logic [3:0]  idx;
  logic [7:0]  code;
  logic [15:0] value;
  logic [15:0] ppm;
  logic [1:0]  level;

  // Current frame byte; the checksum is formed from the held command.
  always_comb begin
    beat.valid   = active;
    beat.tx_byte = frame_byte(code, value, idx);
    beat.last    = (idx == FRAME_LAST);
    beat.ppm     = ppm;
    beat.level   = level;
  end

  // Control: byte 0 leaves directly, so the serializer starts at byte 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= POS_ADDR;
    end else if (advance) begin
      if (idx == FRAME_LAST) begin
        active <= 1'b0;
      end
      idx <= idx + 4'd1;
    end
  end

  // Command and reading snapshot taken with the send beat.
  always_ff @(posedge clk) begin
    if (load) begin
      code  <= command_code;
      value <= command_value;
      ppm   <= ppm_in;
      level <= level_in;
    end
  end

endmodule

`default_nettype wire

@@ hdl/co2_sensor_frame_engine_top.sv @@
// Top level of the sensor frame engine: config registers, input and output handshakes.
//
// Input beats on in_valid/in_ready carry either a send (opcode 0) or one received
// link byte (opcode 1). Result beats leave on out_valid/out_ready from one output
// register. A send yields nine result beats, the command frame bytes with last on
// the ninth; bytes 1 to 8 come from a serializer that feeds the output register.
// A received byte yields a result only when it is the ninth of a response frame.
// An accepted beat's first result appears in the next cycle. Received bytes are taken
// every cycle while in_ready is high; a send blocks input until the serializer has
// passed on its eight remaining bytes. When the receiver stalls, the output register
// holds its beat, and in_ready drops until the serializer has drained and the output
// register is free. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// once; the user must make them while idle, as the block does not enforce it. Reset clears
// the output register and the serializer, restores the threshold and offset registers,
// empties the receive frame, zeroes the reading and shows all lamps.
`default_nettype none

module co2_sensor_frame_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [7:0]  command_code,
  input  wire logic [15:0] command_value,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             tx_valid,
  output logic             last,
  output logic             frame_done,
  output logic             frame_ok,
  output logic [15:0]      ppm_value,
  output logic [1:0]       alarm_level,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import cfe_pkg::*;

  cfg_t       cfg;
  rx_status_t rx_st;
  ser_beat_t  ser;
  logic [15:0] ppm_cur;
  logic [1:0]  level_cur;

  logic out_free;
  logic in_acc;
  logic send_acc;
  logic rx_acc;
  logic ser_adv;

  // Handshake decode.
  always_comb begin
    out_free = !out_valid || out_ready;
    in_ready = !ser.valid && out_free;
    in_acc   = in_valid && in_ready;
    send_acc = in_acc && (opcode == OP_SEND);
    rx_acc   = in_acc && (opcode == OP_RECV);
    ser_adv  = ser.valid && out_free;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn     <= WARN_RESET;
      cfg.critical <= CRITICAL_RESET;
      cfg.offset   <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN:     cfg.warn     <= cfg_data;
        REG_CRITICAL: cfg.critical <= cfg_data;
        REG_OFFSET:   cfg.offset   <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  cfe_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .rx_accept (rx_acc),
    .restart   (send_acc),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .status    (rx_st),
    .ppm_cur   (ppm_cur),
    .level_cur (level_cur)
  );

  cfe_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .load          (send_acc),
    .advance       (ser_adv),
    .command_code  (command_code),
    .command_value (command_value),
    .ppm_in        (ppm_cur),
    .level_in      (level_cur),
    .beat          (ser)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ser_adv || send_acc || (rx_acc && rx_st.done)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload: serializer bytes, the first frame byte, or a response result.
  always_ff @(posedge clk) begin
    priority if (ser_adv) begin
      tx_byte     <= ser.tx_byte;
      tx_valid    <= 1'b1;
      last        <= ser.last;
      frame_done  <= 1'b0;
      frame_ok    <= 1'b0;
      ppm_value   <= ser.ppm;
      alarm_level <= ser.level;
    end else if (send_acc) begin
      tx_byte     <= FRAME_START;
      tx_valid    <= 1'b1;
      last        <= 1'b0;
      frame_done  <= 1'b0;
      frame_ok    <= 1'b0;
      ppm_value   <= ppm_cur;
      alarm_level <= level_cur;
    end else if (rx_acc && rx_st.done) begin
      tx_byte     <= 8'h00;
      tx_valid    <= 1'b0;
      last        <= 1'b1;
      frame_done  <= 1'b1;
      frame_ok    <= rx_st.ok;
      ppm_value   <= rx_st.ppm;
      alarm_level <= rx_st.level;
    end else begin
      tx_byte <= tx_byte;
    end
  end

`ifndef SYNTH
  // A send puts the start byte in the output register on the next cycle.
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    send_acc |=> (out_valid && tx_valid && (tx_byte == FRAME_START)))
    else $error("send beat did not produce the frame start byte");

  // The serializer only runs while the output register holds a frame byte.
  a_ser_behind_out: assert property (@(posedge clk) disable iff (rst)
    ser.valid |-> (out_valid && tx_valid))
    else $error("serializer active with an empty output register");

  // Once the checksum byte is out, the serializer has drained.
  a_last_drained: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid && last) |-> !ser.valid)
    else $error("serializer still active after the last frame byte");
`endif

endmodule

`default_nettype wire
